// ===== rtl/core/ucs2u8_pkg.sv =====
package ucs2u8_pkg;

   // Output buffer size of one name; one byte is always kept for the terminator.
   localparam int NAME_CAPACITY = 256;
   localparam int CNT_W = $clog2(NAME_CAPACITY);
   // Width of the capacity compares: room for the count plus a three-byte character.
   localparam int CMP_W = CNT_W + 2;
   localparam logic [CMP_W-1:0] CAP_WIDE = CMP_W'(NAME_CAPACITY);

   localparam logic [15:0] NUL_CHAR  = 16'h0000;
   localparam logic [15:0] SEMI_CHAR = 16'h003B;
   localparam logic [15:0] DOT_CHAR  = 16'h002E;
   localparam logic [15:0] LIMIT_1B  = 16'h0080;
   localparam logic [15:0] LIMIT_2B  = 16'h0800;
   localparam logic [7:0]  LEAD_2B   = 8'hC0;
   localparam logic [7:0]  LEAD_3B   = 8'hE0;
   localparam logic [7:0]  CONT_MARK = 8'h80;
   localparam logic [5:0]  CONT_MASK = 6'h3F;

   typedef struct packed {
      logic             halted;
      logic [CNT_W-1:0] held_dots;
      logic [CNT_W-1:0] bytes_counted;
   } state_type;

   typedef struct packed {
      logic [7:0] release_dots;
      logic [1:0] byte_count;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
   } result_type;

endpackage

// ===== rtl/core/ucs2u8_enc.sv =====
module ucs2u8_enc
   import ucs2u8_pkg::*;
(
   input  logic [15:0] code_unit,
   input  state_type   state_cur,
   output state_type   state_nxt,
   output result_type  result
);

   logic [CMP_W-1:0] used_wide;
   logic [1:0]       char_bytes;

   assign used_wide = CMP_W'(state_cur.bytes_counted);

   always_comb begin
      state_nxt  = state_cur;
      result     = '0;
      char_bytes = 2'd0;
      if (!state_cur.halted) begin
         if ((used_wide + CMP_W'(1) >= CAP_WIDE) || (code_unit == NUL_CHAR) ||
             (code_unit == SEMI_CHAR)) begin
            state_nxt.halted    = 1'b1;
            state_nxt.held_dots = '0;
         end else if (code_unit == DOT_CHAR) begin
            state_nxt.held_dots     = state_cur.held_dots + CNT_W'(1);
            state_nxt.bytes_counted = state_cur.bytes_counted + CNT_W'(1);
         end else if (code_unit < LIMIT_1B) begin
            result.first_byte = code_unit[7:0];
            char_bytes        = 2'd1;
         end else if (code_unit < LIMIT_2B) begin
            if (used_wide + CMP_W'(2) >= CAP_WIDE) begin
               state_nxt.halted    = 1'b1;
               state_nxt.held_dots = '0;
            end else begin
               result.first_byte  = LEAD_2B | {3'b000, code_unit[10:6]};
               result.second_byte = CONT_MARK | {2'b00, code_unit[5:0] & CONT_MASK};
               char_bytes         = 2'd2;
            end
         end else begin
            if (used_wide + CMP_W'(3) >= CAP_WIDE) begin
               state_nxt.halted    = 1'b1;
               state_nxt.held_dots = '0;
            end else begin
               result.first_byte  = LEAD_3B | {4'b0000, code_unit[15:12]};
               result.second_byte = CONT_MARK | {2'b00, code_unit[11:6] & CONT_MASK};
               result.third_byte  = CONT_MARK | {2'b00, code_unit[5:0] & CONT_MASK};
               char_bytes         = 2'd3;
            end
         end
         // A character that is really emitted releases the dots held before it.
         if (char_bytes != 2'd0) begin
            result.byte_count       = char_bytes;
            result.release_dots     = 8'(state_cur.held_dots);
            state_nxt.held_dots     = '0;
            state_nxt.bytes_counted = state_cur.bytes_counted + CNT_W'(char_bytes);
         end
      end
   end

endmodule

// ===== rtl/core/ucs2_name_to_utf8.sv =====
// Encodes the UCS-2 code units of a file name, one per req transfer, into
// 0 to 3 UTF-8 bytes per rsp transfer; every request yields exactly one
// response. Encoding of a name stops at a zero code unit, at the first ';'
// (the version suffix is dropped), or when a character would not fit in
// NAME_CAPACITY-1 bytes; later units of that name give empty responses.
// Dots are held back and reported in rsp_release_dots just before the next
// emitted character, so trailing dots disappear. The unit marked req_last
// sets rsp_name_end and returns the running state to reset. The block takes
// one code unit per cycle unless the sink stalls. It has an input register,
// one stage of encode logic, and a result register that holds a response
// while the sink stalls.
module ucs2_name_to_utf8
   import ucs2u8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_release_dots,
   output logic [1:0]  rsp_byte_count,
   output logic [7:0]  rsp_first_byte,
   output logic [7:0]  rsp_second_byte,
   output logic [7:0]  rsp_third_byte,
   output logic        rsp_name_end
);

   logic        in_valid_ff;
   logic [15:0] in_code_ff;
   logic        in_last_ff;
   logic        out_valid_ff;
   result_type  out_result_ff;
   logic        out_end_ff;
   state_type   state_ff;
   state_type   state_in;
   state_type   enc_state;
   result_type  enc_result;
   logic        out_free;
   logic        advance;

   ucs2u8_enc u_enc (
      .code_unit (in_code_ff),
      .state_cur (state_ff),
      .state_nxt (enc_state),
      .result    (enc_result)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      state_in = state_ff;
      if (advance) begin
         state_in = in_last_ff ? '0 : enc_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_code_ff <= req_code_unit;
         in_last_ff <= req_last;
      end
      if (advance) begin
         out_result_ff <= enc_result;
         out_end_ff    <= in_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_release_dots = out_result_ff.release_dots;
   assign rsp_byte_count   = out_result_ff.byte_count;
   assign rsp_first_byte   = out_result_ff.first_byte;
   assign rsp_second_byte  = out_result_ff.second_byte;
   assign rsp_third_byte   = out_result_ff.third_byte;
   assign rsp_name_end     = out_end_ff;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench
   import ucs2u8_pkg::*;
;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      result_type enc;
      logic       name_end;
   } expected_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_code_unit = 16'h0000;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_release_dots;
   logic [1:0]  rsp_byte_count;
   logic [7:0]  rsp_first_byte;
   logic [7:0]  rsp_second_byte;
   logic [7:0]  rsp_third_byte;
   logic        rsp_name_end;

   // Running state of the name encoder as the testbench sees it.
   logic [CNT_W-1:0] name_bytes = '0;
   logic [CNT_W-1:0] dots_held = '0;
   logic             name_halted = 1'b0;

   expected_rsp_type expected_q[$];
   int unsigned      error_count = 0;
   int unsigned      rsp_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      stall_left = 0;
   logic             idle_on = 1'b0;

   ucs2_name_to_utf8 dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_unit    (req_code_unit),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_release_dots (rsp_release_dots),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_first_byte   (rsp_first_byte),
      .rsp_second_byte  (rsp_second_byte),
      .rsp_third_byte   (rsp_third_byte),
      .rsp_name_end     (rsp_name_end)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic expected_rsp_type encode_unit(input logic [15:0] cu, input logic lst);
      expected_rsp_type r;
      int unsigned      need;
      r = '0;
      r.name_end = lst;
      if (!name_halted) begin
         if (cu < LIMIT_1B)
            need = 1;
         else if (cu < LIMIT_2B)
            need = 2;
         else
            need = 3;
         // One byte of the buffer always stays free for the terminator.
         if (cu == NUL_CHAR || cu == SEMI_CHAR || int'(name_bytes) + need >= NAME_CAPACITY) begin
            name_halted = 1'b1;
            dots_held = '0;
         end else if (cu == DOT_CHAR) begin
            dots_held++;
            name_bytes++;
         end else begin
            r.enc.byte_count = 2'(need);
            case (need)
               1: r.enc.first_byte = cu[7:0];
               2: begin
                  r.enc.first_byte  = LEAD_2B | 8'(cu[10:6]);
                  r.enc.second_byte = CONT_MARK | 8'(cu[5:0]);
               end
               default: begin
                  r.enc.first_byte  = LEAD_3B | 8'(cu[15:12]);
                  r.enc.second_byte = CONT_MARK | 8'(cu[11:6]);
                  r.enc.third_byte  = CONT_MARK | 8'(cu[5:0]);
               end
            endcase
            r.enc.release_dots = 8'(dots_held);
            dots_held = '0;
            name_bytes = name_bytes + CNT_W'(need);
         end
      end
      if (lst) begin
         name_bytes = '0;
         dots_held = '0;
         name_halted = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("response %0d: %s is 0x%0h, expected 0x%0h", rsp_count, what, got, want);
   endtask

   task automatic check_response();
      expected_rsp_type want;
      rsp_count++;
      if (expected_q.size() == 0) begin
         report_mismatch("response with nothing outstanding, name_end", rsp_name_end, 0);
         return;
      end
      want = expected_q.pop_front();
      if (rsp_release_dots !== want.enc.release_dots)
         report_mismatch("release_dots", rsp_release_dots, want.enc.release_dots);
      if (rsp_byte_count !== want.enc.byte_count)
         report_mismatch("byte_count", rsp_byte_count, want.enc.byte_count);
      if (rsp_first_byte !== want.enc.first_byte)
         report_mismatch("first_byte", rsp_first_byte, want.enc.first_byte);
      if (rsp_second_byte !== want.enc.second_byte)
         report_mismatch("second_byte", rsp_second_byte, want.enc.second_byte);
      if (rsp_third_byte !== want.enc.third_byte)
         report_mismatch("third_byte", rsp_third_byte, want.enc.third_byte);
      if (rsp_name_end !== want.name_end)
         report_mismatch("name_end", rsp_name_end, want.name_end);
   endtask

   // Result side: check every transfer, then decide whether the sink stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_response();
         if (stall_left > 0)
            stall_left--;
         else if (idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 14);
         rsp_ready <= (stall_left == 0);
      end
   end

   task automatic send_unit(input logic [15:0] cu, input logic lst);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_code_unit <= cu;
      req_last      <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(encode_unit(cu, lst));
   endtask

   task automatic send_fill(input int unsigned n, input logic [15:0] cu);
      repeat (n) send_unit(cu, 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   function automatic logic [15:0] pick_unit(input bit plain);
      int unsigned sel;
      sel = $urandom_range(0, plain ? 93 : 99);
      if (sel < 30)
         return 16'($urandom_range(1, 127));
      else if (sel < 50)
         return DOT_CHAR;
      else if (sel < 65)
         return 16'($urandom_range(16'h0080, 16'h07FF));
      else if (sel < 80)
         return 16'($urandom_range(16'h0800, 16'hFFFF));
      else if (sel < 90)
         return 16'($urandom);
      else if (sel < 94) begin
         case ($urandom_range(0, 5))
            0: return 16'h007F;
            1: return LIMIT_1B;
            2: return 16'h07FF;
            3: return LIMIT_2B;
            4: return 16'hFFFF;
            default: return 16'($urandom_range(16'hD800, 16'hDFFF));
         endcase
      end else if (sel < 97)
         return SEMI_CHAR;
      else
         return NUL_CHAR;
   endfunction

   task automatic test_code_ranges();
      send_unit(16'h0041, 1'b1);
      // Range edges of each encoding length, a lone surrogate, and a trailing dot.
      send_unit(16'h007F, 1'b0);
      send_unit(LIMIT_1B, 1'b0);
      send_unit(16'h07FF, 1'b0);
      send_unit(LIMIT_2B, 1'b0);
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'hD800, 1'b0);
      send_unit(DOT_CHAR, 1'b1);
   endtask

   task automatic test_dots_and_stops();
      send_unit(DOT_CHAR, 1'b0);
      send_unit(DOT_CHAR, 1'b0);
      send_unit(16'h0078, 1'b0);
      send_unit(DOT_CHAR, 1'b0);
      send_unit(SEMI_CHAR, 1'b0);
      send_unit(16'h0079, 1'b0);
      send_unit(16'h1234, 1'b1);
      send_unit(DOT_CHAR, 1'b0);
      send_unit(NUL_CHAR, 1'b0);
      send_unit(16'h007A, 1'b1);
      send_unit(NUL_CHAR, 1'b1);
      send_unit(SEMI_CHAR, 1'b1);
   endtask

   task automatic test_capacity();
      // 130 held dots released at once, then a two-byte character with one byte left.
      send_fill(130, DOT_CHAR);
      send_unit(16'h0041, 1'b0);
      send_fill(41, 16'h20AC);
      send_unit(16'h00E9, 1'b0);
      send_unit(16'h0042, 1'b1);
      // Three-byte character that just fits, then an ASCII character that does not.
      send_fill(84, 16'h20AC);
      send_unit(16'h20AC, 1'b0);
      send_unit(16'h0043, 1'b1);
      // Three-byte character that does not fit; the dot held before it is dropped.
      send_fill(84, 16'h20AC);
      send_unit(DOT_CHAR, 1'b0);
      send_unit(16'h20AC, 1'b0);
      send_unit(16'h0044, 1'b1);
      // Two-byte character that just fits, then a dot that no longer fits.
      send_fill(84, 16'h20AC);
      send_unit(16'h0061, 1'b0);
      send_unit(16'h00E9, 1'b0);
      send_unit(DOT_CHAR, 1'b0);
      send_unit(16'h0045, 1'b1);
   endtask

   task automatic test_random_names(input int unsigned count, input bit paced);
      int unsigned sent;
      int unsigned len;
      bit          lengthy;
      sent = 0;
      while (sent < count) begin
         lengthy = ($urandom_range(0, 15) == 0);
         len = lengthy ? $urandom_range(60, 200) : $urandom_range(1, 24);
         for (int unsigned i = 0; i < len; i++)
            send_unit(pick_unit(lengthy), i == len - 1);
         sent += len;
         // Switch between paced and unpaced stretches now and then.
         if (paced && $urandom_range(0, 5) == 0)
            idle_on <= ($urandom_range(0, 2) != 0);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset   <= 1'b0;
      idle_on <= 1'b1;
      test_code_ranges();
      test_dots_and_stops();
      wait_drained();
      test_capacity();
      wait_drained();
      idle_on <= 1'b1;
      test_random_names(110, 1'b1);
      wait_drained();
      idle_on <= 1'b0;
      test_random_names(40, 1'b0);
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
